### rtl/prfl_pkg.sv
// package for the page replacement unit: widths, register indexes, reset values
// and the control structs passed from the top level into the frame cells
// no dependencies
`default_nettype none

package prfl_pkg;

    localparam int unsigned FRAMES_DEF    = 8;
    localparam int unsigned PAGE_BITS_DEF = 16;

    localparam int unsigned PAGE_W   = 16;
    localparam int unsigned FAULT_W  = 16;
    localparam int unsigned RES_CNT_W = 4;
    localparam int unsigned LIMIT_W  = 4;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REPLACE_MODE  = 4'd0,
        REG_FRAMES_IN_USE = 4'd1
    } t_reg_idx;

    localparam logic               REPLACE_MODE_RST  = 1'b0;
    localparam logic [LIMIT_W-1:0] FRAMES_IN_USE_RST = 4'd3;
    localparam logic [FAULT_W-1:0] FAULT_MAX         = '1;

    typedef struct packed {
        logic accept;
        logic hit;
        logic lru;
        logic full;
    } t_cell_cmd;

    typedef struct packed {
        logic filled;
        logic top;
        logic append;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/prfl_ifs.sv
// valid/ready channel interfaces: page request, result and config write
// depends on prfl_pkg for payload widths
`default_nettype none

interface prfl_req_if;
    logic                        valid;
    logic                        ready;
    logic [prfl_pkg::PAGE_W-1:0] page;
    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface prfl_res_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic                           evicted_valid;
    logic [prfl_pkg::PAGE_W-1:0]    evicted_page;
    logic [prfl_pkg::FAULT_W-1:0]   fault_total;
    logic [prfl_pkg::RES_CNT_W-1:0] resident_count;
    modport source (output valid, output hit, output evicted_valid, output evicted_page,
                    output fault_total, output resident_count, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                    input fault_total, input resident_count, output ready);
endinterface

interface prfl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [prfl_pkg::CFG_IDX_W-1:0]  idx;
    logic [prfl_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

### rtl/page_replacement_fifo_lru.sv
// Page replacement unit, FIFO or LRU, built as a row of FRAMES frame cells.
// One page request is accepted per clock; its result appears in the output
// register on the next cycle and a new request is taken while that result waits,
// as long as the result is taken in the same cycle. The cycle time is set by the
// compare of the request against all frames and the hit chain through the row.
// No clearing pass after reset. Depends on prfl_pkg, prfl_ifs and prfl_cell.
`default_nettype none

module page_replacement_fifo_lru #(
    parameter int unsigned FRAMES    = prfl_pkg::FRAMES_DEF,
    parameter int unsigned PAGE_BITS = prfl_pkg::PAGE_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    prfl_req_if.sink    i_req,
    prfl_cfg_if.sink    i_cfg,
    prfl_res_if.source  o_res
);

    localparam int unsigned CW = $clog2(FRAMES + 1);

    logic                                r_mode;
    logic [prfl_pkg::LIMIT_W-1:0]        r_frames_in_use;
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    logic [prfl_pkg::FAULT_W-1:0]        r_fault;
    logic [prfl_pkg::FAULT_W-1:0]        n_fault;

    logic                                r_out_valid;
    logic                                r_res_hit;
    logic                                r_res_ev_valid;
    logic [prfl_pkg::PAGE_W-1:0]         r_res_ev_page;
    logic [prfl_pkg::RES_CNT_W-1:0]      r_res_count;

    logic                                accept;
    logic [31:0]                         page_ext;
    logic [PAGE_BITS-1:0]                page_k;
    logic [7:0]                          lim8;
    logic [7:0]                          count8;
    logic [7:0]                          count_next8;
    logic [31:0]                         evict_ext;
    logic                                hit;
    logic                                full;
    prfl_pkg::t_cell_cmd                 cmd;

    logic [PAGE_BITS-1:0]                cell_data [FRAMES+1];
    logic                                hit_chain [FRAMES+1];

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign page_ext = 32'(i_req.page);
    assign page_k   = page_ext[PAGE_BITS-1:0];
    assign count8   = 8'(r_count);

    always_comb begin
        lim8 = 8'(r_frames_in_use);
        if (lim8 == 8'd0) begin
            lim8 = 8'd1;
        end
        if (lim8 > 8'(FRAMES)) begin
            lim8 = 8'(FRAMES);
        end
    end

    assign full = (count8 >= lim8);
    assign hit  = hit_chain[FRAMES];

    assign cmd.accept = accept;
    assign cmd.hit    = hit;
    assign cmd.lru    = r_mode;
    assign cmd.full   = full;

    assign cell_data[FRAMES] = '0;
    assign hit_chain[0]      = 1'b0;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        prfl_pkg::t_cell_ctl ctl;

        assign ctl.filled = (8'(g) < count8);
        assign ctl.top    = ((8'(g) + 8'd1) == count8);
        assign ctl.append = (8'(g) == count8);

        prfl_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_ctl       (ctl),
            .i_page      (page_k),
            .i_next_data (cell_data[g+1]),
            .i_hit_in    (hit_chain[g]),
            .o_hit_out   (hit_chain[g+1]),
            .o_data      (cell_data[g])
        );
    end

    assign evict_ext = 32'(cell_data[0]);

    always_comb begin
        count_next8 = count8;
        n_count     = r_count;
        n_fault     = r_fault;
        if (!hit) begin
            if (r_fault != prfl_pkg::FAULT_MAX) begin
                n_fault = r_fault + prfl_pkg::FAULT_W'(1);
            end
            if (!full) begin
                count_next8 = count8 + 8'd1;
                n_count     = count_next8[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= prfl_pkg::REPLACE_MODE_RST;
            r_frames_in_use <= prfl_pkg::FRAMES_IN_USE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.idx)
                prfl_pkg::REG_REPLACE_MODE: begin
                    r_mode <= i_cfg.data[0];
                end
                prfl_pkg::REG_FRAMES_IN_USE: begin
                    r_frames_in_use <= i_cfg.data[prfl_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_fault     <= n_fault;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_hit      <= hit;
            r_res_ev_valid <= !hit && full;
            r_res_ev_page  <= (!hit && full) ? evict_ext[prfl_pkg::PAGE_W-1:0] : '0;
            r_res_count    <= count_next8[prfl_pkg::RES_CNT_W-1:0];
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.hit            = r_res_hit;
    assign o_res.evicted_valid  = r_res_ev_valid;
    assign o_res.evicted_page   = r_res_ev_page;
    assign o_res.fault_total    = r_fault;
    assign o_res.resident_count = r_res_count;

endmodule

`default_nettype wire

### rtl/prfl_cell.sv
// one frame of the resident stack: holds a page, compares it with the request
// and takes its upper neighbor's page, the request, or holds; uses prfl_pkg
`default_nettype none

module prfl_cell #(
    parameter int unsigned PAGE_BITS = prfl_pkg::PAGE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire prfl_pkg::t_cell_cmd  i_cmd,
    input  wire prfl_pkg::t_cell_ctl  i_ctl,
    input  wire logic [PAGE_BITS-1:0] i_page,
    input  wire logic [PAGE_BITS-1:0] i_next_data,
    input  wire logic                 i_hit_in,
    output logic                      o_hit_out,
    output logic [PAGE_BITS-1:0]      o_data
);

    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] n_page;
    logic                 match;

    assign match     = i_ctl.filled && (r_page == i_page);
    assign o_hit_out = i_hit_in || match;
    assign o_data    = r_page;

    always_comb begin
        n_page = r_page;
        if (i_cmd.accept) begin
            if (i_cmd.hit) begin
                if (i_cmd.lru) begin
                    if (i_ctl.top) begin
                        n_page = i_page;
                    end else if (i_ctl.filled && o_hit_out) begin
                        n_page = i_next_data;
                    end
                end
            end else if (!i_cmd.full) begin
                if (i_ctl.append) begin
                    n_page = i_page;
                end
            end else begin
                if (i_ctl.top) begin
                    n_page = i_page;
                end else if (i_ctl.filled) begin
                    n_page = i_next_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

endmodule

`default_nettype wire

### sim/tb_page_replacement_fifo_lru.sv
// self-checking testbench for page_replacement_fifo_lru: directed and random page requests
// are checked against a FIFO/LRU frame stack tracker, with idling and stalls on both sides
// depends on rtl/prfl_pkg.sv, rtl/prfl_ifs.sv and the page_replacement_fifo_lru rtl

module tb_page_replacement_fifo_lru;
    timeunit 1ns;
    timeprecision 1ps;

    import prfl_pkg::*;

    localparam int unsigned N_FRAMES    = FRAMES_DEF;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned SEGMENTS    = 6;
    localparam int unsigned SEG_ITEMS   = 77;
    localparam int unsigned POOL_N      = 12;
    localparam logic        MODE_FIFO   = 1'b0;
    localparam logic        MODE_LRU    = 1'b1;
    localparam logic [LIMIT_W-1:0] CORNER_FRAMES [4] = '{4'd1, 4'd8, 4'd0, 4'd15};

    typedef logic [PAGE_W-1:0] page_t;

    typedef struct packed {
        logic                 hit;
        logic                 ev_valid;
        page_t                ev_page;
        logic [FAULT_W-1:0]   faults;
        logic [RES_CNT_W-1:0] resident;
    } page_result_t;

    class frame_stack_tracker;
        page_t              frames [N_FRAMES];
        int unsigned        n_filled;
        logic [FAULT_W-1:0] faults;
        logic               lru_mode;
        logic [LIMIT_W-1:0] frames_cfg;
        page_result_t       pending_results [$];
        int unsigned        n_errors;
        int unsigned        n_checked;
        int unsigned        n_hits;
        int unsigned        n_evicts;
        int unsigned        n_reg_writes;

        function new();
            n_filled     = 0;
            faults       = '0;
            lru_mode     = REPLACE_MODE_RST;
            frames_cfg   = FRAMES_IN_USE_RST;
            n_errors     = 0;
            n_checked    = 0;
            n_hits       = 0;
            n_evicts     = 0;
            n_reg_writes = 0;
        endfunction

        function int unsigned frame_limit();
            if (frames_cfg == 0) begin
                return 1;
            end
            if (frames_cfg > N_FRAMES) begin
                return N_FRAMES;
            end
            return frames_cfg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            n_reg_writes++;
            if (idx == REG_REPLACE_MODE) begin
                lru_mode = data[0];
            end else if (idx == REG_FRAMES_IN_USE) begin
                frames_cfg = data[LIMIT_W-1:0];
            end
        endfunction

        function void note_request(page_t pg);
            page_result_t r;
            int unsigned  lim;
            int unsigned  pos;
            bit           found;
            r     = '0;
            lim   = frame_limit();
            found = 1'b0;
            pos   = 0;
            for (int unsigned i = 0; i < n_filled; i++) begin
                if (!found && frames[i] == pg) begin
                    found = 1'b1;
                    pos   = i;
                end
            end
            if (found) begin
                r.hit = 1'b1;
                if (lru_mode == MODE_LRU) begin
                    for (int unsigned i = pos; i + 1 < n_filled; i++) begin
                        frames[i] = frames[i+1];
                    end
                    frames[n_filled-1] = pg;
                end
            end else begin
                if (faults != FAULT_MAX) begin
                    faults++;
                end
                if (n_filled < lim) begin
                    frames[n_filled] = pg;
                    n_filled++;
                end else begin
                    r.ev_valid = 1'b1;
                    r.ev_page  = frames[0];
                    for (int unsigned i = 0; i + 1 < n_filled; i++) begin
                        frames[i] = frames[i+1];
                    end
                    frames[n_filled-1] = pg;
                end
            end
            r.faults   = faults;
            r.resident = RES_CNT_W'(n_filled);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string fname, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
                n_errors++;
            end
        endfunction

        function void check_result(page_result_t got);
            page_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, actual %0h", $time, got);
                n_errors++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (want.hit) begin
                n_hits++;
            end
            if (want.ev_valid) begin
                n_evicts++;
            end
            compare_field("hit", 16'(want.hit), 16'(got.hit));
            compare_field("evicted_valid", 16'(want.ev_valid), 16'(got.ev_valid));
            compare_field("evicted_page", want.ev_page, got.ev_page);
            compare_field("fault_total", want.faults, got.faults);
            compare_field("resident_count", 16'(want.resident), 16'(got.resident));
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic sink_ready = 1'b0;
    int unsigned src_idle_pct  = 27;
    int unsigned sink_idle_pct = 84;
    int unsigned n_cycles = 0;
    page_t page_pool [POOL_N];

    frame_stack_tracker tracker = new();

    prfl_req_if req_if ();
    prfl_cfg_if cfg_if ();
    prfl_res_if res_if ();

    assign res_if.ready = sink_ready;

    page_replacement_fifo_lru u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always begin
        #2;
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : res_sink
        page_result_t got;
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.hit      = res_if.hit;
                got.ev_valid = res_if.evicted_valid;
                got.ev_page  = res_if.evicted_page;
                got.faults   = res_if.fault_total;
                got.resident = res_if.resident_count;
                tracker.check_result(got);
            end
            sink_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached, %0d results outstanding", $time,
                     tracker.pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_page(input page_t pg);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.page  <= pg;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        tracker.note_request(pg);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (tracker.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // cfg valid stays high across back-to-back writes; caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.idx   <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        tracker.write_reg(idx, data);
    endtask

    task automatic run_segment(input int unsigned seg);
        logic [LIMIT_W-1:0] fr;
        logic               mode;
        int unsigned        span;
        wait_idle();
        fr   = (seg < 4) ? CORNER_FRAMES[seg] : LIMIT_W'($urandom_range(15));
        mode = (seg < 4) ? seg[0] : 1'($urandom);
        write_reg(REG_REPLACE_MODE, {7'($urandom), mode});
        write_reg(REG_FRAMES_IN_USE, {4'($urandom), fr});
        if ($urandom_range(2) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(REG_FRAMES_IN_USE + 1, 15)), 8'($urandom));
        end
        cfg_if.valid <= 1'b0;
        for (int i = 0; i < POOL_N; i++) begin
            page_pool[i] = page_t'($urandom);
        end
        span = tracker.frame_limit() + $urandom_range(0, 3);
        if (span > POOL_N) begin
            span = POOL_N;
        end
        repeat (SEG_ITEMS) begin
            if ($urandom_range(99) < 12) begin
                send_page(page_t'($urandom));
            end else begin
                send_page(page_pool[$urandom_range(span - 1)]);
            end
        end
    endtask

    initial begin : stimulus
        page_t seq_page;
        req_if.valid <= 1'b0;
        req_if.page  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.idx   <= '0;
        cfg_if.data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: fifo, three frames
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0001);
        send_page(16'hFFFF);
        send_page(16'h8000);
        send_page(16'h0000);
        send_page(16'h0001);
        wait_idle();
        write_reg(REG_REPLACE_MODE, {7'd0, MODE_LRU});
        write_reg(REG_FRAMES_IN_USE, 8'd8);
        cfg_if.valid <= 1'b0;
        for (int i = 2; i <= 9; i++) begin
            send_page(page_t'(i));
        end
        send_page(16'h0003);
        send_page(16'h0009);
        send_page(16'h000A);
        // limit dropped below the fill level, then above the frame count
        wait_idle();
        write_reg(REG_FRAMES_IN_USE, 8'd0);
        write_reg(CFG_IDX_W'(REG_FRAMES_IN_USE + 1), 8'hFF);
        cfg_if.valid <= 1'b0;
        send_page(16'hAAAA);
        send_page(16'h5555);
        wait_idle();
        write_reg(REG_FRAMES_IN_USE, 8'hFF);
        cfg_if.valid <= 1'b0;
        send_page(16'h5555);
        send_page(16'h1234);

        for (int phase = 0; phase < 3; phase++) begin
            wait_idle();
            src_idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 84 : 0;
            sink_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 27 : 0;
            for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
                run_segment(seg);
            end
        end

        // fresh pages mixed with pool pages
        wait_idle();
        write_reg(REG_REPLACE_MODE, {7'd0, MODE_LRU});
        write_reg(REG_FRAMES_IN_USE, 8'd8);
        cfg_if.valid <= 1'b0;
        seq_page = page_t'($urandom);
        repeat (20) begin
            send_page(page_pool[$urandom_range(POOL_N - 1)]);
            send_page(seq_page);
            seq_page++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests in fifo and lru modes over %0d register writes",
                 tracker.n_checked, tracker.n_reg_writes);
        $display("saw %0d hits and %0d evictions, fault count ended at %0d",
                 tracker.n_hits, tracker.n_evicts, tracker.faults);
        if (tracker.n_errors == 0 && tracker.pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
